/* rtl/mfrp_pkg.sv */
`default_nettype none
package mfrp_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 7;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int REG_WIDTH_W  = 11;
  localparam int REG_HEIGHT_W = 13;
  localparam int REG_WINDOW_W = 3;

  localparam logic [REG_WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [REG_HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [REG_WINDOW_W-1:0] RST_WINDOW = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WIN_SIDE     = 2'd2
  } reg_index_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic push;
    logic start;
  } sel_cmd_t;

endpackage
`default_nettype wire

/* rtl/mfrp_if.sv */
`default_nettype none
interface mfrp_pix_if;
  import mfrp_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

interface mfrp_med_if;
  import mfrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_value;
  logic             frame_last;
  modport source (output valid, median_value, frame_last, input ready);
  modport sink   (input valid, median_value, frame_last, output ready);
endinterface

interface mfrp_cfg_if;
  import mfrp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/median_filter_replicate_pad_core.sv */
`default_nettype none
// Streaming 2-D median filter with replicated borders, 8-bit grey pixels.
// Channels: pixels (sink) takes kind/pixel requests; kind pixel stores a
// pixel of the frame in raster order, kind drain releases one pending result
// once the frame is complete. results (source) gives median_value and
// frame_last. cfg (sink) writes image width, image height and window side by
// index; a write restarts the frame and pixels is held off in the cycle after it.
// Results lag the pixels by pad*width+pad requests (pad = window/2).
// A request that yields a result is worked through these steps once it is
// accepted: row steps up to the top window row, one line-store read per
// window pixel (single read port), a flush and a start, bit-serial
// selection (a step per pixel bit, MSB first, then done) and the load of
// the output register; the block then goes back to idle for the next
// request, and requests that yield nothing leave it idle. One request is
// worked at a time; the block holds at the end of work only while the
// output register is still full because the receiver stalls. Reset:
// synchronous, restores the register defaults and clears counters; the
// line store is not cleared, entries are read after writing.
module median_filter_replicate_pad_core #(
  parameter int MAX_WIDTH  = mfrp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = mfrp_pkg::DEF_MAX_WINDOW,
  parameter int MAX_HEIGHT = mfrp_pkg::DEF_MAX_HEIGHT
) (
  input wire logic clk,
  input wire logic rst,
  mfrp_pix_if.sink   pixels,
  mfrp_med_if.source results,
  mfrp_cfg_if.sink   cfg
);
  import mfrp_pkg::*;

  localparam int DEPTH   = MAX_WINDOW * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int CW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SW      = $clog2(MAX_WINDOW + 1);
  localparam int NWIN    = MAX_WINDOW * MAX_WINDOW;
  localparam int NW      = $clog2(NWIN + 1);
  localparam int WIN_CAP = (MAX_WINDOW - 1) | 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_GATHER, S_FLUSH, S_START, S_SELECT, S_EMIT
  } state_t;

  state_t state;

  // configuration and derived frame geometry
  logic [REG_WIDTH_W-1:0]  reg_width;
  logic [REG_HEIGHT_W-1:0] reg_height;
  logic [REG_WINDOW_W-1:0] reg_window;
  logic                    settle;
  logic                    cfg_hit;
  logic [WW-1:0] w_eff, ew;
  logic [HW-1:0] h_eff, eh;
  logic [SW-1:0] s_eff, es, pad;
  logic [REG_WINDOW_W-1:0] s_raw;
  logic [CW-1:0] total, lag;
  logic [NW-1:0] nwin;

  // frame position
  logic [CW-1:0] in_cnt, out_cnt;
  logic [AW-1:0] wr_addr, out_base;
  logic [WW-1:0] out_col;
  logic [HW-1:0] out_row;

  // window gather
  logic [HW-1:0] g_row;
  logic [AW-1:0] g_base;
  logic [SW-1:0] pre_cnt, dx, dy;
  logic [SW-1:0] top_hold;
  logic signed [WW+1:0] cc;
  logic [WW-1:0] col;
  logic [AW-1:0] rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic rd_pend;

  logic [PIX_W-1:0] mem [DEPTH];
  logic mem_we;
  logic in_acc;

  sel_cmd_t         sel_cmd;
  logic             sel_done;
  logic [PIX_W-1:0] sel_result;

  logic             out_valid;
  logic [PIX_W-1:0] out_median;
  logic             out_last;

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW+1:0] s;
    if ({1'b0, a} < b) s = {2'b00, a} + (AW+2)'(DEPTH) - {1'b0, b};
    else s = {2'b00, a} - {1'b0, b};
    return s[AW-1:0];
  endfunction

  // effective geometry: zero raised to one, oversize saturated, even window made odd
  always_comb begin
    if (reg_width == '0) w_eff = WW'(1);
    else if (32'(reg_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(reg_width);
    if (reg_height == '0) h_eff = HW'(1);
    else if (32'(reg_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(reg_height);
    s_raw = reg_window | REG_WINDOW_W'(1);
    if (32'(s_raw) > MAX_WINDOW) s_eff = SW'(WIN_CAP);
    else s_eff = SW'(s_raw);
  end

  assign cfg.ready    = 1'b1;
  assign pixels.ready = (state == S_IDLE) && !settle;
  assign in_acc       = pixels.valid && pixels.ready;
  assign mem_we       = in_acc && (pixels.kind == KIND_PIXEL) && (in_cnt < total);

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WIN_SIDE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // replicate the column at the left and right edges
  always_comb begin
    cc = signed'((WW+2)'(out_col)) - signed'((WW+2)'(pad)) + signed'((WW+2)'(dx));
    if (cc < 0) col = '0;
    else if (cc >= signed'((WW+2)'(ew))) col = ew - WW'(1);
    else col = WW'(cc);
    rd_addr = add_mod(g_base, (AW+1)'(col));
  end

  assign sel_cmd.push  = rd_pend;
  assign sel_cmd.start = (state == S_START);

  // line store: one write port for incoming pixels, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= pixels.pixel;
    rd_data <= mem[rd_addr];
  end

  mfrp_select #(
    .NWIN (NWIN),
    .CNTW (NW)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .cmd       (sel_cmd),
    .push_data (rd_data),
    .count     (nwin),
    .done      (sel_done),
    .result    (sel_result)
  );

  assign results.valid        = out_valid;
  assign results.median_value = out_median;
  assign results.frame_last   = out_last;

  // geometry products are registered while settle is high, the cycle after any register write
  always_ff @(posedge clk) begin
    if (settle) begin
      ew    <= w_eff;
      eh    <= h_eff;
      es    <= s_eff;
      pad   <= s_eff >> 1;
      total <= CW'(32'(w_eff) * 32'(h_eff));
      lag   <= CW'(32'(s_eff >> 1) * 32'(w_eff) + 32'(s_eff >> 1));
      nwin  <= NW'(32'(s_eff) * 32'(s_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      settle     <= 1'b1;
      reg_width  <= RST_WIDTH;
      reg_height <= RST_HEIGHT;
      reg_window <= RST_WINDOW;
      in_cnt     <= '0;
      out_cnt    <= '0;
      wr_addr    <= '0;
      out_base   <= '0;
      out_col    <= '0;
      out_row    <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      settle  <= cfg_hit;
      rd_pend <= (state == S_GATHER);
      if (out_valid && results.ready) out_valid <= 1'b0;

      if (cfg.valid) begin
        case (reg_index_t'(cfg.index))
          REG_IMAGE_WIDTH:  reg_width  <= cfg.data[REG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: reg_height <= cfg.data[REG_HEIGHT_W-1:0];
          REG_WIN_SIDE:     reg_window <= cfg.data[REG_WINDOW_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        // restart the frame
        in_cnt   <= '0;
        out_cnt  <= '0;
        wr_addr  <= '0;
        out_base <= '0;
        out_col  <= '0;
        out_row  <= '0;
      end

      case (state)
        S_IDLE: begin
          top_hold <= '0;
          if (in_acc) begin
            if (pixels.kind == KIND_PIXEL) begin
              if (in_cnt < total) begin
                wr_addr <= add_mod(wr_addr, (AW+1)'(1));
                in_cnt  <= in_cnt + CW'(1);
                if ((in_cnt + CW'(1) > lag) && (out_cnt < total)) begin
                  g_row   <= out_row;
                  g_base  <= out_base;
                  pre_cnt <= pad;
                  state   <= S_PRE;
                end
              end
            end else if ((in_cnt >= total) && (out_cnt < total)) begin
              g_row   <= out_row;
              g_base  <= out_base;
              pre_cnt <= pad;
              state   <= S_PRE;
            end
          end
        end
        S_PRE: begin
          // step up to the top window row, clamped at row zero; count the
          // steps lost above the image so that row zero repeats for them
          if (pre_cnt == '0) begin
            dx    <= '0;
            dy    <= '0;
            state <= S_GATHER;
          end else begin
            pre_cnt <= pre_cnt - SW'(1);
            if (g_row != '0) begin
              g_row  <= g_row - HW'(1);
              g_base <= sub_mod(g_base, (AW+1)'(ew));
            end else begin
              top_hold <= top_hold + SW'(1);
            end
          end
        end
        S_GATHER: begin
          if (dx == es - SW'(1)) begin
            dx <= '0;
            if (dy == es - SW'(1)) begin
              state <= S_FLUSH;
            end else begin
              dy <= dy + SW'(1);
              // hold on row zero while above the image, advance a row
              // unless at the bottom edge
              if (top_hold != '0) begin
                top_hold <= top_hold - SW'(1);
              end else if ((HW+1)'(g_row) + (HW+1)'(1) < (HW+1)'(eh)) begin
                g_row  <= g_row + HW'(1);
                g_base <= add_mod(g_base, (AW+1)'(ew));
              end
            end
          end else begin
            dx <= dx + SW'(1);
          end
        end
        S_FLUSH:  state <= S_START;
        S_START:  state <= S_SELECT;
        S_SELECT: begin
          if (sel_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || results.ready) begin
            out_valid  <= 1'b1;
            out_median <= sel_result;
            out_last   <= (out_cnt == total - CW'(1));
            if (out_cnt == total - CW'(1)) begin
              in_cnt   <= '0;
              out_cnt  <= '0;
              wr_addr  <= '0;
              out_base <= '0;
              out_col  <= '0;
              out_row  <= '0;
            end else begin
              out_cnt <= out_cnt + CW'(1);
              if (out_col == ew - WW'(1)) begin
                out_col  <= '0;
                out_row  <= out_row + HW'(1);
                out_base <= add_mod(out_base, (AW+1)'(ew));
              end else begin
                out_col <= out_col + WW'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mfrp_select.sv */
`default_nettype none
module mfrp_select #(
  parameter int NWIN = 49,
  parameter int CNTW = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mfrp_pkg::sel_cmd_t       cmd,
  input  wire logic [mfrp_pkg::PIX_W-1:0] push_data,
  input  wire logic [CNTW-1:0]          count,
  output logic                          done,
  output logic [mfrp_pkg::PIX_W-1:0]    result
);
  import mfrp_pkg::*;

  localparam int BCW = $clog2(PIX_W + 1);

  logic [PIX_W-1:0] win [NWIN];
  logic [NWIN-1:0]  active;
  logic [NWIN-1:0]  msb_vec;
  logic [NWIN-1:0]  init_mask;
  logic [CNTW-1:0]  rank;
  logic [CNTW-1:0]  zeros;
  logic [BCW-1:0]   bits;
  logic             busy;
  logic             take_zero;

  // count candidates whose current bit is zero
  always_comb begin
    zeros = '0;
    for (int i = 0; i < NWIN; i++) begin
      msb_vec[i]   = win[i][PIX_W-1];
      init_mask[i] = (32'(i) < 32'(count));
      zeros        = zeros + CNTW'(active[i] & ~win[i][PIX_W-1]);
    end
    take_zero = (rank < zeros);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win[0] <= push_data;
      for (int i = 1; i < NWIN; i++) win[i] <= win[i-1];
    end else if (busy) begin
      for (int i = 0; i < NWIN; i++) win[i] <= {win[i][PIX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        active <= init_mask;
        rank   <= count >> 1;
        bits   <= BCW'(PIX_W);
      end else if (busy) begin
        result <= {result[PIX_W-2:0], ~take_zero};
        if (take_zero) begin
          active <= active & ~msb_vec;
        end else begin
          rank   <= rank - zeros;
          active <= active & msb_vec;
        end
        bits <= bits - BCW'(1);
        if (bits == BCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/median_filter_replicate_pad_core_tb.sv */
`default_nettype none

// Prediction of the filter, kept as a small class: request bookkeeping,
// the line store copy and the queue of medians still to arrive.
class median_scoreboard;
  localparam int STORE_DEPTH = mfrp_pkg::DEF_MAX_WINDOW * mfrp_pkg::DEF_MAX_WIDTH;

  typedef struct {
    logic [7:0] median_value;
    logic       frame_last;
  } median_t;

  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [2:0]  window_reg;
  logic [7:0]  store [STORE_DEPTH];
  int unsigned pix_count;
  int unsigned med_count;
  median_t     pending [$];
  int          mismatches;
  int          results_seen;
  int          frames_done;

  function new();
    width_reg    = mfrp_pkg::RST_WIDTH;
    height_reg   = mfrp_pkg::RST_HEIGHT;
    window_reg   = mfrp_pkg::RST_WINDOW;
    pix_count    = 0;
    med_count    = 0;
    mismatches   = 0;
    results_seen = 0;
    frames_done  = 0;
  endfunction

  function int unsigned cols();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > mfrp_pkg::DEF_MAX_WIDTH) w = mfrp_pkg::DEF_MAX_WIDTH;
    return w;
  endfunction

  function int unsigned rows();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > mfrp_pkg::DEF_MAX_HEIGHT) h = mfrp_pkg::DEF_MAX_HEIGHT;
    return h;
  endfunction

  function int unsigned side();
    int unsigned s;
    s = window_reg | 3'd1;
    if (s > mfrp_pkg::DEF_MAX_WINDOW) s = (mfrp_pkg::DEF_MAX_WINDOW - 1) | 1;
    return s;
  endfunction

  function void write_reg(mfrp_pkg::reg_index_t idx, logic [12:0] data);
    case (idx)
      mfrp_pkg::REG_IMAGE_WIDTH:  width_reg  = data[10:0];
      mfrp_pkg::REG_IMAGE_HEIGHT: height_reg = data;
      mfrp_pkg::REG_WIN_SIDE:     window_reg = data[2:0];
      default: return;
    endcase
    pix_count = 0;
    med_count = 0;
  endfunction

  function logic [7:0] window_median(int unsigned pos);
    logic [7:0] vals [49];
    logic [7:0] v;
    int n, i, j, pad, r, c, rr, cc, w, h;
    w   = cols();
    h   = rows();
    pad = side() / 2;
    r   = pos / w;
    c   = pos % w;
    n   = 0;
    for (int dy = -pad; dy <= pad; dy++) begin
      rr = r + dy;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      for (int dx = -pad; dx <= pad; dx++) begin
        cc = c + dx;
        if (cc < 0) cc = 0;
        if (cc > w - 1) cc = w - 1;
        vals[n] = store[(rr * w + cc) % STORE_DEPTH];
        n++;
      end
    end
    for (i = 1; i < n; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return vals[n/2];
  endfunction

  // Note an accepted request and queue the median it releases, if any.
  function void note_request(logic kind, logic [7:0] pixel);
    int unsigned total, lag;
    median_t m;
    total = cols() * rows();
    lag   = (side() / 2) * cols() + side() / 2;
    if (kind == mfrp_pkg::KIND_PIXEL) begin
      if (pix_count >= total) return;
      store[pix_count % STORE_DEPTH] = pixel;
      pix_count++;
      if (pix_count <= lag || med_count >= total) return;
    end else begin
      if (pix_count < total || med_count >= total) return;
    end
    m.median_value = window_median(med_count);
    m.frame_last   = (med_count == total - 1);
    pending.push_back(m);
    med_count++;
    if (m.frame_last) begin
      pix_count = 0;
      med_count = 0;
    end
  endfunction

  function void check_result(logic [7:0] median_value, logic frame_last);
    median_t m;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: median %0d last %0b", median_value, frame_last);
      return;
    end
    m = pending.pop_front();
    if (m.frame_last === 1'b1) frames_done++;
    if (median_value !== m.median_value || frame_last !== m.frame_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected median %0d last %0b, got median %0d last %0b",
                 results_seen, m.median_value, m.frame_last, median_value, frame_last);
    end
  endfunction

  function bit frame_open();
    return pix_count != 0 || med_count != 0;
  endfunction
endclass

module median_filter_replicate_pad_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfrp_pkg::*;

  logic clk;
  logic rst;

  mfrp_pix_if pix ();
  mfrp_med_if med ();
  mfrp_cfg_if cfg_ch ();

  median_filter_replicate_pad_core uut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix),
    .results (med),
    .cfg     (cfg_ch)
  );

  median_scoreboard sb = new();

  // Traffic shaping: calm drops all idling, hold_req asks the receiver to
  // stall for a long stretch while the sender keeps pushing.
  bit calm      = 0;
  bit hold_req  = 0;
  int hold_left = 0;
  int requests  = 0;
  int reg_writes = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random back-pressure, or a counted long hold when asked.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      med.ready <= 1'b0;
    end else begin
      med.ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && med.valid && med.ready)
      sb.check_result(med.median_value, med.frame_last);
  end

  // Offer one request, idling first at random; hold valid until taken.
  task automatic send_request(logic kind, logic [7:0] value);
    if (!calm && $urandom_range(99) < 19) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.kind  <= kind;
    pix.pixel <= value;
    do @(posedge clk); while (!pix.ready);
    sb.note_request(kind, value);
    requests++;
  endtask

  // Let the block settle so that a register write lands on an idle core.
  task automatic wait_idle();
    int guard;
    pix.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [12:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] s);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WIN_SIDE, s);
  endtask

  // Push n pixels, with stray drain ticks mixed in before the frame is
  // full (ignored). When the frame is complete, drain it out, with stray
  // pixels mixed in (ignored since the frame is full).
  task automatic run_frame(int n, bit directed_vals);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) send_request(KIND_DRAIN, 8'($urandom));
      if (directed_vals) v = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'($urandom);
      else v = 8'($urandom);
      send_request(KIND_PIXEL, v);
    end
    if (n >= sb.cols() * sb.rows()) begin
      while (sb.frame_open()) begin
        if ($urandom_range(99) < 10) send_request(KIND_PIXEL, 8'($urandom));
        else send_request(KIND_DRAIN, 8'($urandom));
      end
      // Drain with nothing left: ignored.
      send_request(KIND_DRAIN, 8'($urandom));
    end
  endtask

  initial begin
    int w, h, s, goal, phase;
    rst          = 1'b1;
    pix.valid    = 1'b0;
    pix.kind     = KIND_PIXEL;
    pix.pixel    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_WIDTH;
    cfg_ch.data  = '0;
    med.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small frame with extreme pixels, then degenerate sizes.
    set_geometry(13'd4, 13'd3, 13'd3);
    run_frame(12, 1);
    // Zero width, height and window all collapse to a single pixel.
    set_geometry(13'd0, 13'd0, 13'd0);
    run_frame(1, 1);
    // Window of two rounds up to three; a partial frame is cut by a write.
    set_geometry(13'd5, 13'd4, 13'd2);
    run_frame(9, 1);
    // Tall column: height saturates; only a part of the frame is sent.
    set_geometry(13'd1, 13'd8191, 13'd6);
    run_frame(20, 1);

    // Oversized row width saturates; single-pixel window, part of one line.
    set_geometry(13'd2047, 13'd1, 13'd1);
    run_frame(64, 0);

    // Random frames, small sizes, window settings drawn from the whole range.
    goal  = requests + 330;
    phase = 0;
    while (requests < goal) begin
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      s = $urandom_range(0, 7);
      calm = (phase >= 4 && phase < 8);
      set_geometry(13'(w), 13'(h), 13'(s));
      if (phase == 2) begin
        // Back-pressure test: fill the core while results are held.
        set_geometry(13'd8, 13'd6, 13'd3);
        hold_req = 1;
        run_frame(48, 0);
      end else if ($urandom_range(9) == 0) begin
        run_frame($urandom_range(1, 20), 0);
      end else begin
        run_frame(sb.cols() * sb.rows(), 0);
      end
      phase++;
    end
    calm = 0;

    pix.valid <= 1'b0;
    wait_idle();

    $display("covered %0d requests, %0d register writes, %0d medians, %0d frames",
             requests, reg_writes, sb.results_seen, sb.frames_done);
    $display("window sizes 0..7, widths and heights from degenerate to saturated");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d medians missing", sb.mismatches, sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timed out");
    $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire
